>>> design/i2cbs_pkg.sv
// i2cbs_pkg: shared types, codes and the per-phase pin decode for the i2c bit sequencer
// no dependencies

package i2cbs_pkg;

  localparam int unsigned HoldW     = 8;
  localparam logic [HoldW-1:0] HoldReset = 8'd20;
  localparam int unsigned StepW     = 2;
  localparam int unsigned BitW      = 3;

  typedef enum logic [2:0] {
    REQ_RELEASE = 3'd0,
    REQ_START   = 3'd1,
    REQ_STOP    = 3'd2,
    REQ_SEND    = 3'd3,
    REQ_RECV    = 3'd4,
    REQ_ACK     = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EMIT = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic emit_phase;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cmd_ok;
    logic phase_last;
    logic hold_done;
    logic out_free;
  } dp_status_t;

  // one pin write
  typedef struct packed {
    logic drive_scl;
    logic level;
    logic strobe;
    logic last;
  } phase_t;

  function automatic logic req_known(logic [2:0] req);
    return (req == REQ_RELEASE) || (req == REQ_START) || (req == REQ_STOP) ||
           (req == REQ_SEND) || (req == REQ_RECV) || (req == REQ_ACK);
  endfunction

  function automatic phase_t phase_decode(logic [2:0] req, logic [StepW-1:0] step,
                                          logic [BitW-1:0] bit_idx, logic [7:0] wb);
    phase_t p;
    p = '0;
    case (req)
      REQ_RELEASE: begin
        p.drive_scl = (step == 2'd0);
        p.level     = 1'b1;
        p.last      = (step != 2'd0);
      end
      REQ_START: begin
        p.drive_scl = step[0];
        p.level     = ~step[1];
        p.last      = (step == 2'd3);
      end
      REQ_STOP: begin
        p.drive_scl = (step == 2'd1);
        p.level     = (step != 2'd0);
        p.last      = (step == 2'd2);
      end
      REQ_SEND: begin
        p.drive_scl = (step != 2'd0);
        p.level     = (step == 2'd0) ? wb[~bit_idx] : (step == 2'd1);
        p.last      = (step == 2'd2) && (bit_idx == '1);
      end
      REQ_RECV: begin
        p.drive_scl = (step != 2'd0);
        p.level     = (step != 2'd2);
        p.strobe    = (step == 2'd1);
        p.last      = (step == 2'd2) && (bit_idx == '1);
      end
      REQ_ACK: begin
        p.drive_scl = (step != 2'd0);
        p.level     = (step != 2'd2);
        p.strobe    = (step == 2'd1);
        p.last      = (step == 2'd2);
      end
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

>>> design/i2cbs_ctrl.sv
// i2cbs_ctrl: command sequencing state machine of the i2c bit sequencer
// depends on i2cbs_pkg

module i2cbs_ctrl import i2cbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d          = state_q;
    cmd_o.load_item  = accept;
    cmd_o.emit_phase = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && status_i.cmd_ok) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_phase = 1'b1;
          state_d          = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status_i.hold_done) begin
          state_d = status_i.phase_last ? ST_IDLE : ST_EMIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // no phase is written out while a command is being taken in
  a_emit_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_phase |-> !s_axis_tready)
    else $error("phase emitted while accepting input");

  // an accepted known command always leads to a phase emit state
  a_accept_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.cmd_ok) |=> (state_q == ST_EMIT))
    else $error("accepted command did not start");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

endmodule

>>> design/i2cbs_datapath.sv
// i2cbs_datapath: command registers, phase counters, held pin levels, hold timer
// and the output register of the i2c bit sequencer; depends on i2cbs_pkg

module i2cbs_datapath import i2cbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HoldW-1:0] cfg_wdata_i,
  input  logic [2:0]       req_type_i,
  input  logic [7:0]       write_byte_i,
  input  logic [7:0]       sda_levels_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  logic [HoldW-1:0] hold_cfg_q;
  logic [HoldW-1:0] hold_cnt_q, hold_cnt_d;
  logic [2:0]       req_q;
  logic [7:0]       wb_q;
  logic [7:0]       lv_q;
  logic [StepW-1:0] step_q, step_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             done_q;
  logic             out_valid_q;
  logic             out_scl_q, out_sda_q, out_strobe_q, out_ack_q, out_last_q;
  logic [7:0]       out_rbyte_q;
  phase_t           ph;

  assign ph = phase_decode(req_q, step_q, bit_q, wb_q);

  assign status_o.cmd_ok     = req_known(req_type_i);
  assign status_o.phase_last = done_q;
  assign status_o.hold_done  = (hold_cnt_q <= 8'd1);
  assign status_o.out_free   = !out_valid_q || m_axis_tready;

  always_comb begin
    scl_d  = ph.drive_scl ? ph.level : scl_q;
    sda_d  = ph.drive_scl ? sda_q : ph.level;
    step_d = step_q + 2'd1;
    bit_d  = bit_q;
    if ((step_q == 2'd2) && ((req_q == REQ_SEND) || (req_q == REQ_RECV))) begin
      step_d = (req_q == REQ_RECV) ? 2'd1 : 2'd0;
      bit_d  = bit_q + 3'd1;
    end
    if (cmd_i.emit_phase) begin
      hold_cnt_d = (hold_cfg_q == '0) ? 8'd1 : hold_cfg_q;
    end else if (hold_cnt_q != '0) begin
      hold_cnt_d = hold_cnt_q - 8'd1;
    end else begin
      hold_cnt_d = hold_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cfg_q  <= HoldReset;
      hold_cnt_q  <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      step_q      <= '0;
      bit_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hold_cfg_q <= cfg_wdata_i;
      end
      hold_cnt_q <= hold_cnt_d;
      if (cmd_i.load_item) begin
        step_q <= '0;
        bit_q  <= '0;
        done_q <= 1'b0;
      end else if (cmd_i.emit_phase) begin
        scl_q  <= scl_d;
        sda_q  <= sda_d;
        step_q <= step_d;
        bit_q  <= bit_d;
        done_q <= ph.last;
      end
      if (cmd_i.emit_phase) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      req_q <= req_type_i;
      wb_q  <= write_byte_i;
      lv_q  <= sda_levels_i;
    end
    if (cmd_i.emit_phase) begin
      out_scl_q    <= scl_d;
      out_sda_q    <= sda_d;
      out_strobe_q <= ph.strobe;
      out_rbyte_q  <= (ph.last && (req_q == REQ_RECV)) ? lv_q : 8'd0;
      out_ack_q    <= ph.last && (req_q == REQ_ACK) && lv_q[7];
      out_last_q   <= ph.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_ack_q, out_rbyte_q, out_strobe_q, out_sda_q, out_scl_q};
  assign m_axis_tlast  = out_last_q;

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_phase |-> (!out_valid_q || m_axis_tready))
    else $error("result overwritten before transfer");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_phase |=> out_valid_q)
    else $error("emitted phase not presented");

  a_ack_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ack_q) |-> out_last_q)
    else $error("ack bit outside last phase");

  a_rbyte_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_rbyte_q != 8'd0)) |-> out_last_q)
    else $error("read byte outside last phase");

endmodule

>>> design/i2c_master_bit_sequencer.sv
// i2c_master_bit_sequencer: top level, controller plus datapath
// depends on i2cbs_pkg, i2cbs_ctrl, i2cbs_datapath
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser req_type, tdata write_byte, sda_levels
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata pin phase, tlast last_phase
// cfg       in   cfg_we_i                       cfg_wdata_i phase_hold
//
// a command yields 2 to 24 pin phases; each phase is emitted and then held as set by
// phase_hold (a hold of 0 acts as 1); an unknown command is taken in but yields no phase.
// a stalled master side delays the next phase; the output register lets the next command
// be taken while the last phase still waits.
// reset releases both pins (held levels 1) and sets phase_hold to 20.

module i2c_master_bit_sequencer import i2cbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HoldW-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // write_byte [7:0], sda_levels [15:8]
  input  logic [7:0]       s_axis_tuser,   // req_type [2:0], zero above
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // scl_level, sda_level, sample_strobe,
                                           // read_byte [10:3], ack_bit [11], zero above
  output logic             m_axis_tlast    // last_phase
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  i2cbs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  i2cbs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (s_axis_tuser[2:0]),
    .write_byte_i  (s_axis_tdata[7:0]),
    .sda_levels_i  (s_axis_tdata[15:8]),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
